// ===== hdl/ahe_pkg.sv =====
// ----------------------------------------------------------------------------
// ahe_pkg
// Shared constants, types and the datapath command set of the adaptive
// Huffman encoder.
// ----------------------------------------------------------------------------
package ahe_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int WEIGHT_BITS   = 32;
  localparam int CHUNK_BITS    = 32;
  localparam int SYM_W         = 8;
  localparam int NODE_COUNT    = 2 * ALPHABET_SIZE - 1;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int CHUNK_EFF     = (CHUNK_BITS > 32) ? 32 : CHUNK_BITS;
  localparam int CNT_W         = 6;
  localparam int STACK_DEPTH   = NODE_COUNT + 1;
  localparam int STACK_W       = $clog2(STACK_DEPTH);
  localparam int RAW_W         = 4;

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

  localparam weight_t WEIGHT_MAX = '1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_RD_PAR,
    OP_RD_RIGHT,
    OP_PUSH,
    OP_POP,
    OP_SHIFT_STACK,
    OP_SHIFT_RAW,
    OP_SEND,
    OP_NODE_LEAF,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_SPLIT3,
    OP_FULL,
    OP_RD_PAR_P,
    OP_NODE_FROM_PAR,
    OP_RD_W,
    OP_LATCH,
    OP_SCAN,
    OP_SCAN_END,
    OP_CUR_PAR,
    OP_SW_PA,
    OP_SW_PB,
    OP_SW_LA,
    OP_SW_LB,
    OP_SW_OB,
    OP_SW_WA,
    OP_SW_WB,
    OP_INC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic cur_zero;
    logic cur_is_lead;
    logic node_zero;
    logic pnode_zero;
    logic chunk_full;
    logic chunk_any;
    logic stack_any;
    logic bits_left;
    logic out_busy;
    logic seen;
    logic ovf;
    logic room;
    logic root_eq;
    logic scan_more;
  } dp_status_t;

endpackage

// ===== hdl/ahe_sym_if.sv =====
// ----------------------------------------------------------------------------
// ahe_sym_if
// Input channel carrying one byte per request.
// ----------------------------------------------------------------------------
interface ahe_sym_if;
  logic                      valid;
  logic                      ready;
  logic [ahe_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

// ===== hdl/ahe_code_if.sv =====
// ----------------------------------------------------------------------------
// ahe_code_if
// Output channel carrying one chunk of code bits per request.
// ----------------------------------------------------------------------------
interface ahe_code_if;
  logic                          valid;
  logic                          ready;
  logic [ahe_pkg::CHUNK_EFF-1:0] code_bits;
  logic [ahe_pkg::CNT_W-1:0]     bit_count;
  logic                          last_chunk;
  logic                          overflow_error;

  modport source (output valid, output code_bits, output bit_count, output last_chunk,
                  output overflow_error, input ready);
  modport sink (input valid, input code_bits, input bit_count, input last_chunk,
                input overflow_error, output ready);
endinterface

// ===== hdl/ahe_ram.sv =====
// ----------------------------------------------------------------------------
// ahe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ahe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ahe_datapath.sv =====
// ----------------------------------------------------------------------------
// ahe_datapath
// Node tables, code bit stack, chunk packer and update registers, driven one
// command per cycle by the controller.
// ----------------------------------------------------------------------------
module ahe_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ahe_pkg::dp_cmd_t                cmd,
  output ahe_pkg::dp_status_t             status,
  input  logic [ahe_pkg::SYM_W-1:0]       symbol,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ahe_pkg::CHUNK_EFF-1:0]   out_code,
  output logic [ahe_pkg::CNT_W-1:0]       out_count,
  output logic                            out_last,
  output logic                            out_ovf
);

  ahe_pkg::node_t                    cur, par, node, lead, pnode, pa, pb, leaf_r;
  ahe_pkg::node_t                    nyt, next_order, scan_i, sd, ord_a, nn;
  logic                              sv, a_left, b_left, seen_r, ovf_r, scan_hit;
  logic [ahe_pkg::NODE_W:0]          best;
  ahe_pkg::weight_t                  w_node, root_w;
  logic [ahe_pkg::STACK_W-1:0]       depth;
  logic [ahe_pkg::SYM_W-1:0]         sym_r, raw;
  logic [ahe_pkg::RAW_W-1:0]         raw_left;
  logic [ahe_pkg::ALPHABET_SIZE-1:0] seen;
  logic [ahe_pkg::CHUNK_EFF-1:0]     chunk;
  logic [ahe_pkg::CNT_W-1:0]         cnt;

  logic                              par_we, left_we, right_we, ord_we, leaf_we, stk_we;
  ahe_pkg::node_t                    par_wa, par_wd, par_ra, par_rd;
  ahe_pkg::node_t                    left_wa, left_wd, left_ra, left_rd;
  ahe_pkg::node_t                    right_wa, right_wd, right_ra, right_rd;
  ahe_pkg::node_t                    ord_wa, ord_wd, ord_ra, ord_rd;
  ahe_pkg::node_t                    wt_ra, w_addr;
  logic                              w_we, wt_we;
  ahe_pkg::weight_t                  w_data, wt_rd;
  logic [ahe_pkg::SYM_W-1:0]         leaf_wa, leaf_ra;
  ahe_pkg::node_t                    leaf_wd, leaf_rd;
  logic [ahe_pkg::STACK_W-1:0]       stk_wa, stk_ra;
  logic                              stk_wd, stk_rd;

  assign nn = ahe_pkg::node_t'(next_order + 1'b1);

  always_comb begin
    par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = cur;
    left_we = 1'b0; left_wa = '0; left_wd = '0; left_ra = pa;
    right_we = 1'b0; right_wa = '0; right_wd = '0; right_ra = par_rd;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = scan_i;
    w_we = 1'b0; w_addr = '0; w_data = '0; wt_ra = scan_i;
    leaf_we = 1'b0; leaf_wa = sym_r; leaf_wd = '0; leaf_ra = symbol;
    stk_we = 1'b0; stk_wa = depth; stk_wd = 1'b0;
    stk_ra = depth - 1'b1;
    case (cmd.op)
      ahe_pkg::OP_PUSH: begin
        stk_we = 1'b1;
        stk_wd = (right_rd == cur);
      end
      ahe_pkg::OP_SPLIT1: begin
        left_we = 1'b1; left_wa = nyt; left_wd = nn;
        right_we = 1'b1; right_wa = nyt; right_wd = next_order;
        par_we = 1'b1; par_wa = next_order; par_wd = nyt;
        w_we = 1'b1; w_addr = next_order; w_data = ahe_pkg::weight_t'(1);
        ord_we = 1'b1; ord_wa = next_order; ord_wd = next_order;
        leaf_we = 1'b1; leaf_wd = next_order;
      end
      ahe_pkg::OP_SPLIT2: begin
        par_we = 1'b1; par_wa = nn; par_wd = nyt;
        w_we = 1'b1; w_addr = nn; w_data = '0;
        ord_we = 1'b1; ord_wa = nn; ord_wd = nn;
      end
      ahe_pkg::OP_SPLIT3: begin
        w_we = 1'b1; w_addr = nyt; w_data = ahe_pkg::weight_t'(1);
      end
      ahe_pkg::OP_FULL: begin
        w_we = 1'b1; w_addr = nyt; w_data = ahe_pkg::weight_t'(1);
        leaf_we = 1'b1; leaf_wd = nyt;
      end
      ahe_pkg::OP_RD_PAR_P: par_ra = pnode;
      ahe_pkg::OP_RD_W:     wt_ra = node;
      ahe_pkg::OP_SW_PA:    par_ra = lead;
      ahe_pkg::OP_SW_PB:    par_ra = node;
      ahe_pkg::OP_SW_LB: begin
        left_ra = pb;
        ord_ra = lead;
      end
      ahe_pkg::OP_SW_OB:    ord_ra = node;
      ahe_pkg::OP_SW_WA: begin
        if (a_left) begin
          left_we = 1'b1; left_wa = pa; left_wd = node;
        end else begin
          right_we = 1'b1; right_wa = pa; right_wd = node;
        end
        par_we = 1'b1; par_wa = lead; par_wd = pb;
        ord_we = 1'b1; ord_wa = lead; ord_wd = ord_rd;
      end
      ahe_pkg::OP_SW_WB: begin
        if (b_left) begin
          left_we = 1'b1; left_wa = pb; left_wd = lead;
        end else begin
          right_we = 1'b1; right_wa = pb; right_wd = lead;
        end
        par_we = 1'b1; par_wa = node; par_wd = pa;
        ord_we = 1'b1; ord_wa = node; ord_wd = ord_a;
      end
      ahe_pkg::OP_INC: begin
        w_we = 1'b1; w_addr = node; w_data = w_node + 1'b1;
        par_ra = node;
      end
      default: begin
      end
    endcase
  end

  // The root weight lives in a register, so the weight table never needs a reset value.
  assign wt_we = w_we && (w_addr != '0);
  assign scan_hit = sv && (wt_rd == w_node) && ({1'b0, ord_rd} < best);

  ahe_ram #(.WIDTH(ahe_pkg::NODE_W), .DEPTH(ahe_pkg::NODE_COUNT)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd)
  );
  ahe_ram #(.WIDTH(ahe_pkg::NODE_W), .DEPTH(ahe_pkg::NODE_COUNT)) u_left (
    .clk(clk), .we(left_we), .waddr(left_wa), .wdata(left_wd), .raddr(left_ra),
    .rdata(left_rd)
  );
  ahe_ram #(.WIDTH(ahe_pkg::NODE_W), .DEPTH(ahe_pkg::NODE_COUNT)) u_right (
    .clk(clk), .we(right_we), .waddr(right_wa), .wdata(right_wd), .raddr(right_ra),
    .rdata(right_rd)
  );
  ahe_ram #(.WIDTH(ahe_pkg::NODE_W), .DEPTH(ahe_pkg::NODE_COUNT)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
  );
  ahe_ram #(.WIDTH(ahe_pkg::WEIGHT_BITS), .DEPTH(ahe_pkg::NODE_COUNT)) u_weight (
    .clk(clk), .we(wt_we), .waddr(w_addr), .wdata(w_data), .raddr(wt_ra), .rdata(wt_rd)
  );
  ahe_ram #(.WIDTH(ahe_pkg::NODE_W), .DEPTH(ahe_pkg::ALPHABET_SIZE)) u_leaf (
    .clk(clk), .we(leaf_we), .waddr(leaf_wa), .wdata(leaf_wd), .raddr(leaf_ra),
    .rdata(leaf_rd)
  );
  ahe_ram #(.WIDTH(1), .DEPTH(ahe_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nyt <= '0;
      next_order <= ahe_pkg::node_t'(1);
      seen <= '0;
      root_w <= '0;
      out_valid <= 1'b0;
    end else begin
      if (w_we && (w_addr == '0)) begin
        root_w <= w_data;
      end
      if (cmd.op == ahe_pkg::OP_SPLIT3) begin
        next_order <= ahe_pkg::node_t'(next_order + 2'd2);
        nyt <= nn;
      end
      if ((cmd.op == ahe_pkg::OP_SPLIT3) || (cmd.op == ahe_pkg::OP_FULL)) begin
        seen[sym_r] <= 1'b1;
      end
      if (cmd.op == ahe_pkg::OP_SEND) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ahe_pkg::OP_LOAD: begin
        sym_r <= symbol;
        raw <= symbol;
        seen_r <= seen[symbol];
        raw_left <= seen[symbol] ? '0 : ahe_pkg::RAW_W'(ahe_pkg::SYM_W);
        ovf_r <= (root_w == ahe_pkg::WEIGHT_MAX);
        depth <= '0;
        chunk <= '0;
        cnt <= '0;
      end
      ahe_pkg::OP_START: begin
        leaf_r <= leaf_rd;
        cur <= seen_r ? leaf_rd : nyt;
      end
      ahe_pkg::OP_RD_RIGHT: par <= par_rd;
      ahe_pkg::OP_PUSH: begin
        depth <= depth + 1'b1;
        cur <= par;
      end
      ahe_pkg::OP_POP: depth <= depth - 1'b1;
      ahe_pkg::OP_SHIFT_STACK: begin
        chunk <= {chunk[ahe_pkg::CHUNK_EFF-2:0], stk_rd};
        cnt <= cnt + 1'b1;
      end
      ahe_pkg::OP_SHIFT_RAW: begin
        chunk <= {chunk[ahe_pkg::CHUNK_EFF-2:0], raw[ahe_pkg::SYM_W-1]};
        raw <= {raw[ahe_pkg::SYM_W-2:0], 1'b0};
        raw_left <= raw_left - 1'b1;
        cnt <= cnt + 1'b1;
      end
      ahe_pkg::OP_SEND: begin
        out_code <= chunk;
        out_count <= cnt;
        out_last <= !status.bits_left;
        out_ovf <= ovf_r;
        chunk <= '0;
        cnt <= '0;
      end
      ahe_pkg::OP_NODE_LEAF: node <= leaf_r;
      ahe_pkg::OP_SPLIT1, ahe_pkg::OP_FULL: pnode <= nyt;
      ahe_pkg::OP_NODE_FROM_PAR: node <= par_rd;
      ahe_pkg::OP_LATCH: begin
        w_node <= (node == '0) ? root_w : wt_rd;
        lead <= node;
        best <= '1;
        scan_i <= ahe_pkg::node_t'(1);
        sv <= 1'b0;
      end
      ahe_pkg::OP_SCAN: begin
        sv <= 1'b1;
        sd <= scan_i;
        scan_i <= scan_i + 1'b1;
      end
      ahe_pkg::OP_SCAN_END: begin
        sv <= 1'b0;
        cur <= node;
      end
      ahe_pkg::OP_CUR_PAR: cur <= par_rd;
      ahe_pkg::OP_SW_PB: pa <= par_rd;
      ahe_pkg::OP_SW_LA: pb <= par_rd;
      ahe_pkg::OP_SW_LB: a_left <= (left_rd == lead);
      ahe_pkg::OP_SW_OB: begin
        b_left <= (left_rd == node);
        ord_a <= ord_rd;
      end
      default: begin
      end
    endcase
    if (((cmd.op == ahe_pkg::OP_SCAN) || (cmd.op == ahe_pkg::OP_SCAN_END)) && scan_hit) begin
      best <= {1'b0, ord_rd};
      lead <= sd;
    end
  end

  always_comb begin
    status.in_range = {1'b0, symbol} < (ahe_pkg::SYM_W + 1)'(ahe_pkg::ALPHABET_SIZE);
    status.cur_zero = (cur == '0);
    status.cur_is_lead = (cur == lead);
    status.node_zero = (node == '0);
    status.pnode_zero = (pnode == '0);
    status.chunk_full = (cnt == ahe_pkg::CNT_W'(ahe_pkg::CHUNK_EFF));
    status.chunk_any = (cnt != '0);
    status.stack_any = (depth != '0);
    status.bits_left = (depth != '0) || (raw_left != '0);
    status.out_busy = out_valid;
    status.seen = seen_r;
    status.ovf = ovf_r;
    status.room = ({1'b0, next_order} + 2'd2) <= (ahe_pkg::NODE_W + 1)'(ahe_pkg::NODE_COUNT);
    status.root_eq = (root_w == w_node);
    status.scan_more = (scan_i < next_order);
  end

  a_send_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ahe_pkg::OP_SEND |-> !out_valid) else $error("chunk sent over a pending one");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ahe_pkg::OP_POP |-> depth != '0) else $error("pop from empty code stack");
  a_split_alloc: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ahe_pkg::OP_SPLIT3 |=> next_order == ahe_pkg::node_t'($past(next_order) + 2'd2))
    else $error("split did not allocate two nodes");
  a_root_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ahe_pkg::OP_INC) && (node == '0) |=> root_w == $past(root_w) + 1'b1)
    else $error("root weight not raised by one");

endmodule

// ===== hdl/ahe_controller.sv =====
// ----------------------------------------------------------------------------
// ahe_controller
// Sequencer for code path walk, chunk emission, tree split and weight update.
// ----------------------------------------------------------------------------
module ahe_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ahe_pkg::dp_status_t status,
  output ahe_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_WALK_A, S_WALK_B, S_WALK_C, S_EMIT, S_EMIT_SH, S_UPD,
    S_SPLIT2, S_SPLIT3, S_PCHK, S_PNODE, S_RD_W, S_LATCH, S_LEADER, S_SCAN,
    S_CHK, S_CHK_B, S_SW_PA, S_SW_PB, S_SW_LA, S_SW_LB, S_SW_OB, S_SW_WA,
    S_SW_WB, S_INC, S_NEXT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op = ahe_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && status.in_range) begin
          cmd.op = ahe_pkg::OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.op = ahe_pkg::OP_START;
        state_next = S_WALK_A;
      end
      S_WALK_A: begin
        if (status.cur_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.op = ahe_pkg::OP_RD_PAR;
          state_next = S_WALK_B;
        end
      end
      S_WALK_B: begin
        cmd.op = ahe_pkg::OP_RD_RIGHT;
        state_next = S_WALK_C;
      end
      S_WALK_C: begin
        cmd.op = ahe_pkg::OP_PUSH;
        state_next = S_WALK_A;
      end
      S_EMIT: begin
        if (status.chunk_full || (!status.bits_left && status.chunk_any)) begin
          if (!status.out_busy) begin
            cmd.op = ahe_pkg::OP_SEND;
          end
        end else if (!status.bits_left) begin
          state_next = S_UPD;
        end else if (status.stack_any) begin
          cmd.op = ahe_pkg::OP_POP;
          state_next = S_EMIT_SH;
        end else begin
          cmd.op = ahe_pkg::OP_SHIFT_RAW;
        end
      end
      S_EMIT_SH: begin
        cmd.op = ahe_pkg::OP_SHIFT_STACK;
        state_next = S_EMIT;
      end
      S_UPD: begin
        if (status.ovf) begin
          state_next = S_IDLE;
        end else if (status.seen) begin
          cmd.op = ahe_pkg::OP_NODE_LEAF;
          state_next = S_RD_W;
        end else if (status.room) begin
          cmd.op = ahe_pkg::OP_SPLIT1;
          state_next = S_SPLIT2;
        end else begin
          cmd.op = ahe_pkg::OP_FULL;
          state_next = S_PCHK;
        end
      end
      S_SPLIT2: begin
        cmd.op = ahe_pkg::OP_SPLIT2;
        state_next = S_SPLIT3;
      end
      S_SPLIT3: begin
        cmd.op = ahe_pkg::OP_SPLIT3;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (status.pnode_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.op = ahe_pkg::OP_RD_PAR_P;
          state_next = S_PNODE;
        end
      end
      S_PNODE, S_NEXT: begin
        cmd.op = ahe_pkg::OP_NODE_FROM_PAR;
        state_next = S_RD_W;
      end
      S_RD_W: begin
        cmd.op = ahe_pkg::OP_RD_W;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.op = ahe_pkg::OP_LATCH;
        state_next = S_LEADER;
      end
      S_LEADER: begin
        state_next = status.root_eq ? S_INC : S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_more) begin
          cmd.op = ahe_pkg::OP_SCAN;
        end else begin
          cmd.op = ahe_pkg::OP_SCAN_END;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (status.cur_is_lead) begin
          state_next = S_INC;
        end else if (status.cur_zero) begin
          state_next = S_SW_PA;
        end else begin
          cmd.op = ahe_pkg::OP_RD_PAR;
          state_next = S_CHK_B;
        end
      end
      S_CHK_B: begin
        cmd.op = ahe_pkg::OP_CUR_PAR;
        state_next = S_CHK;
      end
      S_SW_PA: begin
        cmd.op = ahe_pkg::OP_SW_PA;
        state_next = S_SW_PB;
      end
      S_SW_PB: begin
        cmd.op = ahe_pkg::OP_SW_PB;
        state_next = S_SW_LA;
      end
      S_SW_LA: begin
        cmd.op = ahe_pkg::OP_SW_LA;
        state_next = S_SW_LB;
      end
      S_SW_LB: begin
        cmd.op = ahe_pkg::OP_SW_LB;
        state_next = S_SW_OB;
      end
      S_SW_OB: begin
        cmd.op = ahe_pkg::OP_SW_OB;
        state_next = S_SW_WA;
      end
      S_SW_WA: begin
        cmd.op = ahe_pkg::OP_SW_WA;
        state_next = S_SW_WB;
      end
      S_SW_WB: begin
        cmd.op = ahe_pkg::OP_SW_WB;
        state_next = S_INC;
      end
      S_INC: begin
        cmd.op = ahe_pkg::OP_INC;
        state_next = status.node_zero ? S_IDLE : S_NEXT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/adaptive_huffman_encoder.sv =====
// ----------------------------------------------------------------------------
// adaptive_huffman_encoder
// FGK adaptive Huffman encoder over bytes, emitting code in chunks of up to
// 32 bits with the final chunk of each symbol marked.
// ----------------------------------------------------------------------------
// One byte is taken at a time; the next is accepted once the previous one's
// tree update is complete. For each byte the controller walks its code path
// level by level, shifts out each path bit and raw bit, sends each chunk, and
// for each level of the weight update, unless the root has the same weight,
// runs a leader search that reads the weight and order of every allocated
// non-root node through one RAM port, then the ancestor check and any swap. The
// tree tables need no clearing pass after reset.
module adaptive_huffman_encoder (
  input logic       clk,
  input logic       rst,
  ahe_sym_if.sink   symbols,
  ahe_code_if.source codes
);

  ahe_pkg::dp_cmd_t    cmd;
  ahe_pkg::dp_status_t status;

  ahe_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(symbols.valid), .in_ready(symbols.ready),
    .status(status), .cmd(cmd)
  );

  ahe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .symbol(symbols.symbol),
    .out_valid(codes.valid), .out_ready(codes.ready), .out_code(codes.code_bits),
    .out_count(codes.bit_count), .out_last(codes.last_chunk),
    .out_ovf(codes.overflow_error)
  );

endmodule

// ===== tb/adaptive_huffman_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_huffman_encoder_tb
// Drives bytes into the encoder and checks every code chunk against an
// in-bench FGK tree model, with random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module adaptive_huffman_encoder_tb;

  localparam int WATCHDOG_LIMIT = 500000;
  localparam int DRAIN_CYCLES   = 2000;

  typedef struct {
    logic [ahe_pkg::CHUNK_EFF-1:0] code_bits;
    logic [ahe_pkg::CNT_W-1:0]     bit_count;
    logic                          last_chunk;
    logic                          overflow_error;
  } chunk_t;

  logic clk;
  logic rst;

  ahe_sym_if  syms ();
  ahe_code_if codes ();

  adaptive_huffman_encoder DUT (
    .clk(clk),
    .rst(rst),
    .symbols(syms.sink),
    .codes(codes.source)
  );

  // Tree model state.
  int               tree_par  [ahe_pkg::NODE_COUNT];
  int               tree_left [ahe_pkg::NODE_COUNT];
  int               tree_right[ahe_pkg::NODE_COUNT];
  ahe_pkg::weight_t tree_wt   [ahe_pkg::NODE_COUNT];
  int               tree_ord  [ahe_pkg::NODE_COUNT];
  int               sym_leaf  [256];
  bit               sym_seen  [256];
  int               nyt_node;
  int               alloc_count;

  chunk_t  pending_chunks[$];
  int      mismatches;
  bit      idle_on;
  int      hold_cycles;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int find_leader(int nd);
    int best;
    int best_ord;
    best = nd;
    best_ord = 65535;
    if (tree_wt[0] == tree_wt[nd]) return nd;
    for (int i = 1; i < alloc_count && i < ahe_pkg::NODE_COUNT; i++) begin
      if (tree_wt[i] == tree_wt[nd] && tree_ord[i] < best_ord) begin
        best_ord = tree_ord[i];
        best = i;
      end
    end
    return best;
  endfunction

  function automatic bit is_ancestor_or_self(int nd, int target);
    int cur;
    int steps;
    cur = nd;
    steps = 0;
    while (cur != 0 && steps < ahe_pkg::NODE_COUNT) begin
      if (cur == target) return 1'b1;
      cur = tree_par[cur];
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic void swap_nodes(int a, int b);
    int pa;
    int pb;
    bit a_left;
    bit b_left;
    int t;
    pa = tree_par[a];
    pb = tree_par[b];
    a_left = (tree_left[pa] == a);
    b_left = (tree_left[pb] == b);
    if (a_left) tree_left[pa] = b; else tree_right[pa] = b;
    if (b_left) tree_left[pb] = a; else tree_right[pb] = a;
    tree_par[a] = pb;
    tree_par[b] = pa;
    t = tree_ord[a];
    tree_ord[a] = tree_ord[b];
    tree_ord[b] = t;
  endfunction

  function automatic void raise_weights(int nd);
    int lead;
    int steps;
    steps = 0;
    while (steps < ahe_pkg::NODE_COUNT) begin
      lead = find_leader(nd);
      if (lead != nd && !is_ancestor_or_self(nd, lead)) swap_nodes(lead, nd);
      tree_wt[nd] = tree_wt[nd] + 1'b1;
      if (nd == 0) break;
      nd = tree_par[nd];
      steps++;
    end
  endfunction

  function automatic void append_path(int nd, ref bit bits[$]);
    bit rev[$];
    int cur;
    int p;
    cur = nd;
    while (cur != 0 && rev.size() < ahe_pkg::NODE_COUNT) begin
      p = tree_par[cur];
      rev = {rev, bit'(tree_right[p] == cur)};
      cur = p;
    end
    for (int i = rev.size() - 1; i >= 0; i--) bits = {bits, rev[i]};
  endfunction

  function automatic void encode_symbol(logic [ahe_pkg::SYM_W-1:0] s);
    bit     bits[$];
    bit     ovf;
    int     p;
    int     cnt;
    chunk_t c;
    if (sym_seen[s]) begin
      append_path(sym_leaf[s], bits);
    end else begin
      append_path(nyt_node, bits);
      for (int i = ahe_pkg::SYM_W - 1; i >= 0; i--) bits = {bits, bit'(s[i])};
    end
    ovf = (tree_wt[0] == ahe_pkg::WEIGHT_MAX);
    if (!ovf) begin
      if (sym_seen[s]) begin
        raise_weights(sym_leaf[s]);
      end else begin
        p = nyt_node;
        if (alloc_count + 2 <= ahe_pkg::NODE_COUNT) begin
          tree_left[p] = alloc_count + 1;
          tree_right[p] = alloc_count;
          tree_par[alloc_count] = p;
          tree_par[alloc_count + 1] = p;
          tree_left[alloc_count] = 0;
          tree_right[alloc_count] = 0;
          tree_left[alloc_count + 1] = 0;
          tree_right[alloc_count + 1] = 0;
          tree_wt[alloc_count] = ahe_pkg::weight_t'(1);
          tree_wt[alloc_count + 1] = '0;
          tree_ord[alloc_count] = alloc_count;
          tree_ord[alloc_count + 1] = alloc_count + 1;
          tree_wt[p] = ahe_pkg::weight_t'(1);
          sym_leaf[s] = alloc_count;
          nyt_node = alloc_count + 1;
          alloc_count += 2;
        end else begin
          tree_wt[p] = ahe_pkg::weight_t'(1);
          sym_leaf[s] = p;
        end
        sym_seen[s] = 1'b1;
        if (p != 0) raise_weights(tree_par[p]);
      end
    end
    for (int k = 0; k < bits.size(); k += ahe_pkg::CHUNK_EFF) begin
      cnt = bits.size() - k;
      if (cnt > ahe_pkg::CHUNK_EFF) cnt = ahe_pkg::CHUNK_EFF;
      c.code_bits = '0;
      for (int i = 0; i < cnt; i++) begin
        c.code_bits = {c.code_bits[ahe_pkg::CHUNK_EFF-2:0], bits[k + i]};
      end
      c.bit_count = ahe_pkg::CNT_W'(cnt);
      c.last_chunk = (k + cnt >= bits.size());
      c.overflow_error = ovf;
      pending_chunks = {pending_chunks, c};
    end
  endfunction

  task automatic send_symbol(logic [ahe_pkg::SYM_W-1:0] s);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      syms.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    syms.valid = 1'b1;
    syms.symbol = s;
    do @(posedge clk); while (!syms.ready);
    encode_symbol(s);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    syms.valid = 1'b0;
    while (pending_chunks.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold when requested.
  initial begin
    codes.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        codes.ready = 1'b0;
        hold_cycles--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        codes.ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        codes.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    chunk_t e;
    if (!rst && codes.valid && codes.ready) begin
      if (pending_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected chunk: bits=%h count=%0d", codes.code_bits, codes.bit_count);
      end else begin
        e = pending_chunks.pop_front();
        if (codes.code_bits !== e.code_bits || codes.bit_count !== e.bit_count ||
            codes.last_chunk !== e.last_chunk || codes.overflow_error !== e.overflow_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Chunk mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                     e.code_bits, e.bit_count, e.last_chunk, e.overflow_error,
                     codes.code_bits, codes.bit_count, codes.last_chunk,
                     codes.overflow_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (syms.valid && syms.ready) || (codes.valid && codes.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    send_symbol(8'h00);
    send_symbol(8'hFF);
    send_symbol(8'h55);
    send_symbol(8'hAA);
    send_symbol(8'h00);
    send_symbol(8'hFF);
  endtask

  task automatic test_repeats();
    for (int i = 0; i < 8; i++) send_symbol(8'h55);
    for (int i = 0; i < 6; i++) send_symbol(i[0] ? 8'hAA : 8'h00);
  endtask

  // Every byte once in shuffled order, covering the last-new-symbol case.
  task automatic test_full_alphabet();
    logic [ahe_pkg::SYM_W-1:0] order[256];
    logic [ahe_pkg::SYM_W-1:0] t;
    int j;
    for (int i = 0; i < 256; i++) order[i] = ahe_pkg::SYM_W'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 256; i++) send_symbol(order[i]);
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int i = 0; i < 20; i++) send_symbol(ahe_pkg::SYM_W'($urandom_range(0, 255)));
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (50) @(negedge clk);
    for (int i = 0; i < 10; i++) send_symbol(ahe_pkg::SYM_W'($urandom_range(0, 7)));
  endtask

  task automatic test_random_skewed(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) send_symbol(ahe_pkg::SYM_W'($urandom_range(0, 15)));
      else send_symbol(ahe_pkg::SYM_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    mismatches = 0;
    hold_cycles = 0;
    idle_on = 1'b1;
    for (int i = 0; i < ahe_pkg::NODE_COUNT; i++) tree_wt[i] = '0;
    nyt_node = 0;
    alloc_count = 1;
    rst = 1'b1;
    syms.valid = 1'b0;
    syms.symbol = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_repeats();
    test_full_alphabet();
    test_backpressure();
    test_drain_pause();
    test_random_skewed(120);
    idle_on = 1'b0;
    test_random_skewed(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_chunks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== adaptive_huffman_encoder.f =====
hdl/ahe_pkg.sv
hdl/ahe_sym_if.sv
hdl/ahe_code_if.sv
hdl/ahe_ram.sv
hdl/ahe_datapath.sv
hdl/ahe_controller.sv
hdl/adaptive_huffman_encoder.sv
tb/adaptive_huffman_encoder_tb.sv
